/* rtl/tcwc_pkg.sv */
// ----------------------------------------------------------------------------
// tcwc_pkg
// Shared types and codes of the congestion window controller: item
// function codes, result codes, register indexes, queue entry layout and
// the command and status words between controller and datapath.
// ----------------------------------------------------------------------------
package tcwc_pkg;

  // field widths
  localparam int FUNC_W  = 2;
  localparam int SEQ_W   = 16;
  localparam int SIZE_W  = 11;
  localparam int TIME_W  = 32;
  localparam int WIN_W   = 16;
  localparam int CODE_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

  // ack result codes
  localparam logic [CODE_W-1:0] ACK_ADVANCED = 3'd0;
  localparam logic [CODE_W-1:0] ACK_FAST_RTX = 3'd1;
  localparam logic [CODE_W-1:0] ACK_DUP      = 3'd2;
  localparam logic [CODE_W-1:0] ACK_STALE    = 3'd3;
  localparam logic [CODE_W-1:0] ACK_NONE     = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RTO_MS        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SSTHRESH = 1'd1;

  // reset values
  localparam logic [WIN_W-1:0] RTO_RESET      = 16'd500;
  localparam logic [WIN_W-1:0] SSTHRESH_RESET = 16'd15360;
  localparam logic [WIN_W-1:0] WIN_MAX        = 16'hFFFF;

  // duplicate count that triggers fast retransmit
  localparam logic [1:0] DUP_LIMIT = 2'd3;

  // one outstanding segment
  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic latch;   // capture the accepted word
    logic rd_en;   // read head entry of the queue
    logic exec;    // run one step of the item
    logic first;   // first step of the item
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop;     // a segment was retired, fetch the next head
    logic refresh; // push step ran, fetch the head once more
  } dp_stat_t;

endpackage

/* rtl/tcwc_datapath.sv */
// ----------------------------------------------------------------------------
// tcwc_datapath
// Outstanding segment queue, window state and timer. Executes one step of
// an item per command: a push, a duplicate or stale check, one segment pop,
// or a timeout check. Result fields are held for the report cycle.
// ----------------------------------------------------------------------------
module tcwc_datapath #(
  parameter int SEGMENT_BYTES = 1024,
  parameter int QUEUE_DEPTH   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcwc_pkg::dp_cmd_t                   cmd,
  output tcwc_pkg::dp_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [tcwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcwc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [tcwc_pkg::FUNC_W-1:0]         in_func,
  input  logic [tcwc_pkg::SEQ_W-1:0]          in_seq_num,
  input  logic [tcwc_pkg::SIZE_W-1:0]         in_seg_bytes,
  input  logic [tcwc_pkg::SEQ_W-1:0]          in_ack_num,
  input  logic [tcwc_pkg::TIME_W-1:0]         in_now_ms,
  output logic [tcwc_pkg::CODE_W-1:0]         out_ack_code,
  output logic                                out_timed_out,
  output logic [tcwc_pkg::WIN_W-1:0]          out_cwnd_bytes,
  output logic [tcwc_pkg::WIN_W-1:0]          out_ssthresh_bytes,
  output logic                                out_in_avoidance,
  output logic [tcwc_pkg::SEQ_W-1:0]          out_oldest_seq,
  output logic                                out_queue_empty,
  output logic                                out_queue_full,
  output logic [tcwc_pkg::TIME_W-1:0]         out_send_base
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [tcwc_pkg::WIN_W-1:0] SEG = tcwc_pkg::WIN_W'(SEGMENT_BYTES);

  // captured item word
  logic [tcwc_pkg::FUNC_W-1:0] func_r;
  logic [tcwc_pkg::SEQ_W-1:0]  seq_r;
  logic [tcwc_pkg::SIZE_W-1:0] bytes_r;
  logic [tcwc_pkg::SEQ_W-1:0]  ack_r;
  logic [tcwc_pkg::TIME_W-1:0] now_r;

  // queue storage
  tcwc_pkg::entry_t mem [QUEUE_DEPTH];
  tcwc_pkg::entry_t rd_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] tail;
  logic [IDX_W:0]   tail_sum;
  logic             wr_en;

  // window state
  logic [tcwc_pkg::WIN_W-1:0]  cwnd_r, cwnd_nxt;
  logic [tcwc_pkg::WIN_W-1:0]  ssth_r, ssth_nxt;
  logic                        avoid_r, avoid_nxt;
  logic [1:0]                  dup_r, dup_nxt;
  logic [tcwc_pkg::WIN_W-1:0]  cd_r, cd_nxt;
  logic [tcwc_pkg::TIME_W-1:0] acked_r, acked_nxt;
  logic [tcwc_pkg::TIME_W-1:0] ts_r, ts_nxt;
  logic [tcwc_pkg::WIN_W-1:0]  rto_r;

  // result fields
  logic [tcwc_pkg::CODE_W-1:0] code_r, code_nxt;
  logic                        fired_r, fired_nxt;

  // helpers
  logic [tcwc_pkg::WIN_W:0]    grow_sum;
  logic [tcwc_pkg::WIN_W-1:0]  grown;
  logic [tcwc_pkg::WIN_W-1:0]  half;
  logic [tcwc_pkg::WIN_W-1:0]  reduced_ssth;
  logic [tcwc_pkg::WIN_W-1:0]  cd_dec;
  logic [1:0]                  dup_inc;
  logic [tcwc_pkg::TIME_W-1:0] elapsed;
  logic                        q_empty;
  logic                        q_full;
  logic                        pop_ok;

  assign q_empty  = (count_r == '0);
  assign q_full   = (count_r == DEPTH_CNT);
  assign tail_sum = (IDX_W + 1)'(head_r) + (IDX_W + 1)'(count_r);
  assign tail     = (tail_sum >= DEPTH_EXT) ? IDX_W'(tail_sum - DEPTH_EXT)
                                            : IDX_W'(tail_sum);

  // saturating window growth and loss reduction
  assign grow_sum     = {1'b0, cwnd_r} + {1'b0, SEG};
  assign grown        = grow_sum[tcwc_pkg::WIN_W] ? tcwc_pkg::WIN_MAX
                                                  : grow_sum[tcwc_pkg::WIN_W-1:0];
  assign half         = cwnd_r >> 1;
  assign reduced_ssth = (half > SEG) ? half : SEG;
  assign cd_dec       = cd_r - 1'b1;
  assign dup_inc      = dup_r + 1'b1;
  assign elapsed      = now_r - ts_r;
  assign pop_ok       = !q_empty && (rd_r.seq < ack_r);

  // one step of the current item
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    cwnd_nxt  = cwnd_r;
    ssth_nxt  = ssth_r;
    avoid_nxt = avoid_r;
    dup_nxt   = dup_r;
    cd_nxt    = cd_r;
    acked_nxt = acked_r;
    ts_nxt    = ts_r;
    code_nxt  = code_r;
    fired_nxt = fired_r;
    wr_en     = 1'b0;
    stat      = '0;
    if (cmd.exec) begin
      fired_nxt = 1'b0;
      code_nxt  = tcwc_pkg::ACK_NONE;
      case (func_r)
        tcwc_pkg::FUNC_PUSH: begin
          if (!q_full) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          stat.refresh = 1'b1;
        end
        tcwc_pkg::FUNC_ACK: begin
          if (cmd.first && q_empty) begin
            code_nxt = tcwc_pkg::ACK_STALE;
          end else if (cmd.first && ack_r == rd_r.seq) begin
            // duplicate, third one cuts the window
            if (dup_inc == tcwc_pkg::DUP_LIMIT) begin
              ssth_nxt  = reduced_ssth;
              cwnd_nxt  = SEG;
              avoid_nxt = 1'b0;
              dup_nxt   = '0;
              code_nxt  = tcwc_pkg::ACK_FAST_RTX;
            end else begin
              dup_nxt  = dup_inc;
              code_nxt = tcwc_pkg::ACK_DUP;
            end
          end else if (cmd.first && ack_r < rd_r.seq) begin
            code_nxt = tcwc_pkg::ACK_STALE;
          end else if (pop_ok) begin
            // retire the head segment; grow the window in slow start, or in avoidance once the countdown runs out
            acked_nxt = acked_r + tcwc_pkg::TIME_W'(rd_r.size);
            cd_nxt    = cd_dec;
            if (!avoid_r) begin
              cwnd_nxt = grown;
              if (grown >= ssth_r) begin
                avoid_nxt = 1'b1;
                cd_nxt    = grown;
              end
            end else if (cd_dec == '0) begin
              cwnd_nxt = grown;
              cd_nxt   = grown;
            end
            head_nxt  = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
            count_nxt = count_r - 1'b1;
            stat.pop  = 1'b1;
          end else begin
            ts_nxt   = now_r;
            code_nxt = tcwc_pkg::ACK_ADVANCED;
          end
        end
        tcwc_pkg::FUNC_CHECK: begin
          if (now_r >= ts_r && elapsed >= tcwc_pkg::TIME_W'(rto_r)) begin
            fired_nxt = 1'b1;
            ssth_nxt  = reduced_ssth;
            cwnd_nxt  = SEG;
            avoid_nxt = 1'b0;
            dup_nxt   = '0;
          end
        end
        default: begin
          fired_nxt = 1'b0;
        end
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r  <= in_func;
      seq_r   <= in_seq_num;
      bytes_r <= in_seg_bytes;
      ack_r   <= in_ack_num;
      now_r   <= in_now_ms;
    end
  end

  // queue memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= '{seq: seq_r, size: bytes_r};
    end
    if (cmd.rd_en) begin
      rd_r <= mem[head_r];
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    fired_r <= fired_nxt;
  end

  // control state; the threshold register only matters through reset,
  // which restores its default, so a write to it is taken and dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      cwnd_r  <= SEG;
      ssth_r  <= tcwc_pkg::SSTHRESH_RESET;
      avoid_r <= 1'b0;
      dup_r   <= '0;
      cd_r    <= '0;
      acked_r <= '0;
      ts_r    <= '0;
      rto_r   <= tcwc_pkg::RTO_RESET;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      cwnd_r  <= cwnd_nxt;
      ssth_r  <= ssth_nxt;
      avoid_r <= avoid_nxt;
      dup_r   <= dup_nxt;
      cd_r    <= cd_nxt;
      acked_r <= acked_nxt;
      ts_r    <= ts_nxt;
      if (cfg_we && cfg_index == tcwc_pkg::REG_RTO_MS) begin
        rto_r <= cfg_data;
      end
    end
  end

  // result word
  assign out_ack_code       = code_r;
  assign out_timed_out      = fired_r;
  assign out_cwnd_bytes     = cwnd_r;
  assign out_ssthresh_bytes = ssth_r;
  assign out_in_avoidance   = avoid_r;
  assign out_oldest_seq     = q_empty ? '0 : rd_r.seq;
  assign out_queue_empty    = q_empty;
  assign out_queue_full     = q_full;
  assign out_send_base      = acked_r;

endmodule

/* rtl/tcwc_ctrl.sv */
// ----------------------------------------------------------------------------
// tcwc_ctrl
// Sequencer of the congestion window controller. Steps each item through
// head fetch and execute, refreshes the head after a push, loops once per
// retired segment, and raises the result strobe for one cycle.
// ----------------------------------------------------------------------------
module tcwc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  output tcwc_pkg::dp_cmd_t  cmd,
  input  tcwc_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_READ    = 5'b00010,
    S_EXEC    = 5'b00100,
    S_REFRESH = 5'b01000,
    S_REPORT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;
  logic   accept;

  // a new word may enter while the previous result is shown
  assign busy   = !(state_r == S_IDLE || state_r == S_REPORT);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    unique case (state_r)
      S_IDLE, S_REPORT: begin
        if (accept) begin
          state_nxt = S_READ;
          first_nxt = 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        first_nxt = 1'b0;
        if (stat.pop) begin
          state_nxt = S_READ;
        end else if (stat.refresh) begin
          state_nxt = S_REFRESH;
        end else begin
          state_nxt = S_REPORT;
        end
      end
      S_REFRESH: begin
        state_nxt = S_REPORT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  // datapath commands
  assign cmd.latch = accept;
  assign cmd.rd_en = (state_r == S_READ) || (state_r == S_REFRESH);
  assign cmd.exec  = (state_r == S_EXEC);
  assign cmd.first = first_r;
  assign out_valid = (state_r == S_REPORT);

endmodule

/* rtl/tcp_congestion_window_control_top.sv */
// ----------------------------------------------------------------------------
// tcp_congestion_window_control_top
// From accept, each item steps through head fetch and execute; an ack repeats
// head fetch and update per retired segment (through the single queue read
// port), and a push adds a head refresh. A new word is taken in the result
// cycle, so a word waits for the result before it. Results cannot be stalled.
// Synchronous active-low reset: empty queue, cwnd one segment, ssthresh and
// timeout at their defaults.
// ----------------------------------------------------------------------------
module tcp_congestion_window_control_top #(
  parameter int SEGMENT_BYTES = 1024,
  parameter int QUEUE_DEPTH   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [tcwc_pkg::FUNC_W-1:0]         in_func,
  input  logic [tcwc_pkg::SEQ_W-1:0]          in_seq_num,
  input  logic [tcwc_pkg::SIZE_W-1:0]         in_seg_bytes,
  input  logic [tcwc_pkg::SEQ_W-1:0]          in_ack_num,
  input  logic [tcwc_pkg::TIME_W-1:0]         in_now_ms,
  output logic                                out_valid,
  output logic [tcwc_pkg::CODE_W-1:0]         out_ack_code,
  output logic                                out_timed_out,
  output logic [tcwc_pkg::WIN_W-1:0]          out_cwnd_bytes,
  output logic [tcwc_pkg::WIN_W-1:0]          out_ssthresh_bytes,
  output logic                                out_in_avoidance,
  output logic [tcwc_pkg::SEQ_W-1:0]          out_oldest_seq,
  output logic                                out_queue_empty,
  output logic                                out_queue_full,
  output logic [tcwc_pkg::TIME_W-1:0]         out_send_base,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tcwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tcwc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tcwc_pkg::dp_cmd_t  cmd;
  tcwc_pkg::dp_stat_t stat;

  // registers are to be written only while idle; the block does not enforce it, so the port never waits
  assign cfg_ready = 1'b1;

  tcwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  tcwc_datapath #(
    .SEGMENT_BYTES (SEGMENT_BYTES),
    .QUEUE_DEPTH   (QUEUE_DEPTH)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_valid && cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_func            (in_func),
    .in_seq_num         (in_seq_num),
    .in_seg_bytes       (in_seg_bytes),
    .in_ack_num         (in_ack_num),
    .in_now_ms          (in_now_ms),
    .out_ack_code       (out_ack_code),
    .out_timed_out      (out_timed_out),
    .out_cwnd_bytes     (out_cwnd_bytes),
    .out_ssthresh_bytes (out_ssthresh_bytes),
    .out_in_avoidance   (out_in_avoidance),
    .out_oldest_seq     (out_oldest_seq),
    .out_queue_empty    (out_queue_empty),
    .out_queue_full     (out_queue_full),
    .out_send_base      (out_send_base)
  );

endmodule

/* rtl/tcwc_checker.sv */
// ----------------------------------------------------------------------------
// tcwc_checker
// Port-level checks of the congestion window controller, bound to the top
// level.
// ----------------------------------------------------------------------------
module tcwc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [tcwc_pkg::SEQ_W-1:0]  out_oldest_seq,
  input logic                        out_queue_empty,
  input logic                        out_queue_full
);

  // an accepted word keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // the result cycle is open for the next word
  a_strobe_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy raised during result cycle");

  // queue can not be empty and full at once
  a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_queue_empty && out_queue_full))
    else $error("queue reported empty and full");

  // empty queue reports no oldest sequence
  a_empty_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_queue_empty) |-> (out_oldest_seq == '0))
    else $error("oldest sequence nonzero on empty queue");

endmodule

bind tcp_congestion_window_control_top tcwc_checker u_tcwc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_oldest_seq  (out_oldest_seq),
  .out_queue_empty (out_queue_empty),
  .out_queue_full  (out_queue_full)
);
